FILE: hw/rtl/lpfc_pkg.sv
// ----------------------------------------------------------------------------
// lpfc_pkg
// Shared types and constants of the length-prefixed frame checker.
// ----------------------------------------------------------------------------
package lpfc_pkg;

    localparam int LPFC_MAX_PAYLOAD = 32;

    localparam logic [7:0] LPFC_COMMA   = 8'h2C;
    localparam logic [7:0] LPFC_CHAR_0  = 8'h30;
    localparam logic [7:0] LPFC_CHAR_9  = 8'h39;
    localparam logic [1:0] LPFC_FLD_LEN = 2'd2;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_LEN     = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_CHK     = 4'b1000
    } t_phase;

    typedef enum logic [3:0] {
        ST_RUN   = 4'b0001,
        ST_RD    = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_COMMA = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_BYTE,
        LD_COMMA,
        LD_ERROR
    } t_load;

    typedef struct packed {
        logic  take;
        logic  rd_en;
        logic  idx_clr;
        logic  idx_inc;
        t_load load;
    } t_cmd;

    typedef struct packed {
        logic frame_done;
        logic frame_err;
        logic payload_empty;
        logic idx_last;
        logic out_empty;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/length_prefixed_frame_checker_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_checker_core
// Results: a dropped-frame or comma-only result is valid the cycle after the closing
// word; the first payload byte of a good frame is read in ST_RD and loaded in ST_WAIT.
// Throughput: one word per cycle while a frame is parsed; a word waits while a result
// is still held. A good frame blocks input while it is replayed, since the store's
// registered read port needs one read state and one load state per payload byte.
// Reset: synchronous, active low; parser expects a header, no result pending.
// ----------------------------------------------------------------------------
module length_prefixed_frame_checker_core import lpfc_pkg::*; #(
    parameter int MAX_PAYLOAD = LPFC_MAX_PAYLOAD
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_record_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_frame_error,
    output logic       o_last
);

    t_cmd cmd;
    t_sts sts;
    logic ready;

    lpfc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_ready (ready)
    );

    lpfc_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_data_byte   (i_data_byte),
        .i_record_end  (i_record_end),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_frame_error (o_frame_error),
        .o_last        (o_last)
    );

    assign o_stall = !ready;

`ifndef SYNTH
    a_no_take_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> !o_valid)
        else $error("word accepted while a result is pending");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_error) |-> (o_last && (o_out_byte == 8'h00)))
        else $error("malformed error result");

    a_record_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_record_end) |=> o_stall)
        else $error("record end did not close the frame");
`endif

endmodule

FILE: hw/rtl/lpfc_ram.sv
// ----------------------------------------------------------------------------
// lpfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/lpfc_datapath.sv
// ----------------------------------------------------------------------------
// lpfc_datapath
// Frame parser registers, payload store, replay index and output register.
// ----------------------------------------------------------------------------
module lpfc_datapath import lpfc_pkg::*; #(
    parameter int MAX_PAYLOAD = LPFC_MAX_PAYLOAD
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic [7:0] i_data_byte,
    input  logic       i_record_end,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_frame_error,
    output logic       o_last
);

    localparam int         AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [6:0] MAX_C = 7'(MAX_PAYLOAD);

    t_phase     r_phase,  n_phase;
    logic [6:0] r_count,  n_count;
    logic [6:0] r_len,    n_len;
    logic [9:0] r_sum,    n_sum;
    logic [6:0] r_fd_val, n_fd_val;
    logic       r_fd_stop, n_fd_stop;
    logic [1:0] r_fd_cnt, n_fd_cnt;
    logic [6:0] r_emit_cnt, n_emit_cnt;
    logic [6:0] r_idx,    n_idx;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_err,  n_out_err;
    logic       r_out_last, n_out_last;

    logic       is_digit;
    logic [3:0] dval;
    logic [6:0] dg_val;
    logic       dg_stop;
    logic [1:0] dg_cnt;
    logic       dg_done;
    logic [6:0] cnt_inc;
    logic       chk_done;
    logic       finish;
    logic [6:0] cval;
    logic       frame_err;
    logic       we;
    logic [7:0] rdata;
    logic       out_free;

    assign is_digit = (i_data_byte >= LPFC_CHAR_0) && (i_data_byte <= LPFC_CHAR_9);
    assign dval     = 4'(i_data_byte - LPFC_CHAR_0);
    assign cnt_inc  = r_count + 7'd1;

    // one character of a decimal field
    always_comb begin
        dg_val  = r_fd_val;
        dg_stop = r_fd_stop;
        if (!r_fd_stop) begin
            if (is_digit) begin
                dg_val = {r_fd_val[3:0], 3'b000} + {r_fd_val[5:0], 1'b0} + {3'b000, dval};
            end else begin
                dg_stop = 1'b1;
            end
        end
        dg_cnt  = r_fd_cnt + 2'd1;
        dg_done = (dg_cnt == LPFC_FLD_LEN);
    end

    // frame parser next state, before the frame close
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_len     = r_len;
        n_sum     = r_sum;
        n_fd_val  = r_fd_val;
        n_fd_stop = r_fd_stop;
        n_fd_cnt  = r_fd_cnt;
        chk_done  = 1'b0;
        we        = 1'b0;
        case (r_phase)
            PH_HEADER: begin
                n_count   = '0;
                n_len     = '0;
                n_sum     = '0;
                n_fd_val  = '0;
                n_fd_stop = 1'b0;
                n_fd_cnt  = '0;
                n_phase   = PH_LEN;
            end
            PH_LEN: begin
                n_fd_val  = dg_val;
                n_fd_stop = dg_stop;
                n_fd_cnt  = dg_cnt;
                if (dg_done) begin
                    n_len     = dg_val;
                    n_fd_val  = '0;
                    n_fd_stop = 1'b0;
                    n_fd_cnt  = '0;
                    n_phase   = (dg_val != 7'd0) ? PH_PAYLOAD : PH_CHK;
                end
            end
            PH_PAYLOAD: begin
                we      = (r_len <= MAX_C) && (r_count < MAX_C);
                n_sum   = r_sum + {6'b000000, (is_digit ? dval : 4'd0)};
                n_count = cnt_inc;
                if (cnt_inc >= r_len) begin
                    n_phase = PH_CHK;
                end
            end
            PH_CHK: begin
                n_fd_val  = dg_val;
                n_fd_stop = dg_stop;
                n_fd_cnt  = dg_cnt;
                chk_done  = dg_done;
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
        finish    = chk_done || (i_record_end && (n_phase != PH_HEADER));
        cval      = (n_phase == PH_CHK) ? n_fd_val : 7'd0;
        frame_err = (n_len > MAX_C) || (n_sum != {3'b000, cval});
        if (finish) begin
            n_phase = PH_HEADER;
        end
    end

    lpfc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_emit_cnt = r_emit_cnt;
        if (i_cmd.take && finish) begin
            n_emit_cnt = n_count;
        end
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + 7'd1;
        end
        n_out_valid = r_out_valid && i_stall;
        n_out_byte  = r_out_byte;
        n_out_err   = r_out_err;
        n_out_last  = r_out_last;
        case (i_cmd.load)
            LD_BYTE: begin
                n_out_valid = 1'b1;
                n_out_byte  = rdata;
                n_out_err   = 1'b0;
                n_out_last  = 1'b0;
            end
            LD_COMMA: begin
                n_out_valid = 1'b1;
                n_out_byte  = LPFC_COMMA;
                n_out_err   = 1'b0;
                n_out_last  = 1'b1;
            end
            LD_ERROR: begin
                n_out_valid = 1'b1;
                n_out_byte  = 8'h00;
                n_out_err   = 1'b1;
                n_out_last  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_count     <= '0;
            r_len       <= '0;
            r_sum       <= '0;
            r_fd_val    <= '0;
            r_fd_stop   <= 1'b0;
            r_fd_cnt    <= '0;
            r_emit_cnt  <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_phase   <= n_phase;
                r_count   <= n_count;
                r_len     <= n_len;
                r_sum     <= n_sum;
                r_fd_val  <= n_fd_val;
                r_fd_stop <= n_fd_stop;
                r_fd_cnt  <= n_fd_cnt;
            end
            r_emit_cnt  <= n_emit_cnt;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_err  <= n_out_err;
        r_out_last <= n_out_last;
    end

    assign o_sts.frame_done    = finish;
    assign o_sts.frame_err     = frame_err;
    assign o_sts.payload_empty = (n_count == 7'd0);
    assign o_sts.idx_last      = ((r_idx + 7'd1) == r_emit_cnt);
    assign o_sts.out_empty     = !r_out_valid;
    assign o_sts.out_free      = out_free;

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_frame_error = r_out_err;
    assign o_last        = r_out_last;

endmodule

FILE: hw/rtl/lpfc_ctrl.sv
// ----------------------------------------------------------------------------
// lpfc_ctrl
// Controller: accepts words, loads an error or comma-only result, or replays a validated payload from the store.
// ----------------------------------------------------------------------------
module lpfc_ctrl import lpfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_ready
);

    t_state r_state, n_state;

    always_comb begin
        n_state       = r_state;
        o_ready       = 1'b0;
        o_cmd.take    = 1'b0;
        o_cmd.rd_en   = 1'b0;
        o_cmd.idx_clr = 1'b0;
        o_cmd.idx_inc = 1'b0;
        o_cmd.load    = LD_NONE;
        case (r_state)
            ST_RUN: begin
                o_ready    = i_sts.out_empty;
                o_cmd.take = i_valid && i_sts.out_empty;
                if (o_cmd.take && i_sts.frame_done) begin
                    if (i_sts.frame_err) begin
                        o_cmd.load = LD_ERROR;
                    end else if (i_sts.payload_empty) begin
                        o_cmd.load = LD_COMMA;
                    end else begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = ST_RD;
                    end
                end
            end
            ST_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load    = LD_BYTE;
                    o_cmd.idx_inc = 1'b1;
                    n_state       = i_sts.idx_last ? ST_COMMA : ST_RD;
                end
            end
            ST_COMMA: begin
                if (i_sts.out_free) begin
                    o_cmd.load = LD_COMMA;
                    n_state    = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for length_prefixed_frame_checker_core. A word stream of framed
// ASCII text (directed corner frames, then random good, bad-checksum, cut,
// oversize and noise frames) is pushed through the valid/stall input while
// the output side stalls on its own pattern. A scoreboard tracks the frame
// parser word by word and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
    import lpfc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int STREAM_WORDS = 260;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_error;
        logic       last;
    } t_frame_result;

    typedef struct {
        bit [7:0] data;
        bit       rec_end;
    } t_stream_word;

    typedef enum {FK_GOOD, FK_BAD_SUM, FK_CUT, FK_OVERSIZE} t_frame_kind;

    class t_frame_scoreboard;
        t_phase          phase;
        bit [6:0]        field_count;
        bit [6:0]        frame_length;
        bit [9:0]        digit_sum;
        bit [6:0]        fld_value;
        bit              fld_stop;
        bit [1:0]        fld_cnt;
        bit [7:0]        payload_mem[LPFC_MAX_PAYLOAD];
        t_frame_result   expected_q[$];
        int              n_err;
        int              n_words;
        int              n_results;
        int              n_good;
        int              n_dropped;

        function new();
            phase        = PH_HEADER;
            field_count  = '0;
            frame_length = '0;
            digit_sum    = '0;
            fld_value    = '0;
            fld_stop     = 1'b0;
            fld_cnt      = '0;
            foreach (payload_mem[i]) payload_mem[i] = '0;
        endfunction

        static function bit is_digit(bit [7:0] b);
            return b >= LPFC_CHAR_0 && b <= LPFC_CHAR_9;
        endfunction

        // value of leading digits; count of characters wraps at 4
        function bit [1:0] take_field_char(bit [7:0] b);
            if (!fld_stop) begin
                if (is_digit(b)) begin
                    fld_value = 7'(fld_value * 10 + (b - LPFC_CHAR_0));
                end else begin
                    fld_stop = 1'b1;
                end
            end
            fld_cnt++;
            return fld_cnt;
        endfunction

        function void close_frame();
            bit [6:0]      chk;
            t_frame_result r;
            chk   = (phase == PH_CHK) ? fld_value : 7'd0;
            phase = PH_HEADER;
            if (frame_length > LPFC_MAX_PAYLOAD || digit_sum != chk) begin
                r = '{out_byte: 8'h00, frame_error: 1'b1, last: 1'b1};
                expected_q.push_back(r);
                n_dropped++;
            end else begin
                for (int i = 0; i < field_count && i < LPFC_MAX_PAYLOAD; i++) begin
                    r = '{out_byte: payload_mem[i], frame_error: 1'b0, last: 1'b0};
                    expected_q.push_back(r);
                end
                r = '{out_byte: LPFC_COMMA, frame_error: 1'b0, last: 1'b1};
                expected_q.push_back(r);
                n_good++;
            end
        endfunction

        function void note_word(bit [7:0] b, bit rec_end);
            bit closed;
            closed = 1'b0;
            n_words++;
            case (phase)
                PH_HEADER: begin
                    field_count  = '0;
                    frame_length = '0;
                    digit_sum    = '0;
                    fld_value    = '0;
                    fld_stop     = 1'b0;
                    fld_cnt      = '0;
                    phase        = PH_LEN;
                end
                PH_LEN: begin
                    if (take_field_char(b) == LPFC_FLD_LEN) begin
                        frame_length = fld_value;
                        fld_value    = '0;
                        fld_stop     = 1'b0;
                        fld_cnt      = '0;
                        phase        = (frame_length != 0) ? PH_PAYLOAD : PH_CHK;
                    end
                end
                PH_PAYLOAD: begin
                    if (frame_length <= LPFC_MAX_PAYLOAD && field_count < LPFC_MAX_PAYLOAD)
                        payload_mem[field_count[4:0]] = b;
                    if (is_digit(b))
                        digit_sum = digit_sum + 10'(b - LPFC_CHAR_0);
                    field_count = field_count + 7'd1;
                    if (field_count >= frame_length)
                        phase = PH_CHK;
                end
                default: begin
                    if (take_field_char(b) == LPFC_FLD_LEN) begin
                        close_frame();
                        closed = 1'b1;
                    end
                end
            endcase
            if (!closed && rec_end && phase != PH_HEADER)
                close_frame();
        endfunction

        function void check_result(logic [7:0] act_byte, logic act_err, logic act_last);
            t_frame_result exp_r;
            n_results++;
            if (expected_q.size() == 0) begin
                $error("unexpected word: out_byte=%h frame_error=%b last=%b",
                       act_byte, act_err, act_last);
                n_err++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (act_byte !== exp_r.out_byte) begin
                $error("out_byte: expected %h, got %h", exp_r.out_byte, act_byte);
                n_err++;
            end
            if (act_err !== exp_r.frame_error) begin
                $error("frame_error: expected %b, got %b", exp_r.frame_error, act_err);
                n_err++;
            end
            if (act_last !== exp_r.last) begin
                $error("last: expected %b, got %b", exp_r.last, act_last);
                n_err++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_data_byte;
    logic       i_record_end;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_frame_error;
    logic       o_last;

    t_frame_scoreboard sb;
    t_stream_word      stream_q[$];
    int                cycle_cnt = 0;

    length_prefixed_frame_checker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_record_end  (i_record_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_frame_error (o_frame_error),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void add_word(bit [7:0] b, bit rec_end);
        stream_q.push_back('{b, rec_end});
    endfunction

    function automatic void add_text(string s, bit rec_last);
        for (int i = 0; i < s.len(); i++)
            add_word(s[i], rec_last && (i == s.len() - 1));
    endfunction

    function automatic bit [7:0] rand_other();
        bit [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b >= LPFC_CHAR_0 && b <= LPFC_CHAR_9);
        return b;
    endfunction

    // two-char field; sometimes ended early by a non-digit
    function automatic void push_field(ref t_stream_word fw[$], input int v);
        if (v == 0 && $urandom_range(0, 3) == 0) begin
            fw.push_back('{rand_other(), 1'b0});
            fw.push_back('{8'($urandom_range(0, 255)), 1'b0});
        end else if (v <= 9 && $urandom_range(0, 3) == 0) begin
            fw.push_back('{8'(LPFC_CHAR_0 + v), 1'b0});
            fw.push_back('{rand_other(), 1'b0});
        end else begin
            fw.push_back('{8'(LPFC_CHAR_0 + v / 10), 1'b0});
            fw.push_back('{8'(LPFC_CHAR_0 + v % 10), 1'b0});
        end
    endfunction

    function automatic void add_frame(t_frame_kind kind, int len_req);
        t_stream_word fw[$];
        int           len;
        int           sum;
        int           chk;
        int           cut_at;
        int           d;
        if (len_req >= 0)
            len = len_req;
        else if (kind == FK_OVERSIZE)
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 99) : $urandom_range(33, 40);
        else if ($urandom_range(0, 3) == 0)
            len = $urandom_range(7, LPFC_MAX_PAYLOAD);
        else
            len = $urandom_range(0, 6);
        sum = 0;
        fw.push_back('{8'($urandom_range(0, 255)), 1'b0});
        push_field(fw, len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 2) == 0 && sum <= 90) begin
                d = $urandom_range(0, 9);
                sum += d;
                fw.push_back('{8'(LPFC_CHAR_0 + d), 1'b0});
            end else begin
                fw.push_back('{rand_other(), 1'b0});
            end
        end
        chk = (kind == FK_BAD_SUM) ? (sum + $urandom_range(1, 99)) % 100 : sum;
        push_field(fw, chk);
        fw[fw.size() - 1].rec_end = ($urandom_range(0, 3) == 0);
        if (kind == FK_CUT) begin
            cut_at = $urandom_range(0, fw.size() - 1);
            while (fw.size() > cut_at + 1) void'(fw.pop_back());
            fw[cut_at].rec_end = 1'b1;
        end
        foreach (fw[i]) stream_q.push_back(fw[i]);
    endfunction

    // random bytes, closed by an end-of-record word so the parser resyncs
    function automatic void add_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            add_word(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
        stream_q[stream_q.size() - 1].rec_end = 1'b1;
    endfunction

    function automatic void build_stream();
        int pick;
        add_text("H0000", 1'b0);               // zero length, comma only
        add_text("@1x", 1'b0);                 // length ends at non-digit
        add_word(8'h00, 1'b0);                 // NUL payload byte
        add_text("0!", 1'b0);
        add_text("#40", 1'b0);                 // oversize, cut short
        add_word(8'hFF, 1'b0);
        add_word("7", 1'b1);
        add_word(8'h80, 1'b1);                 // end of record on header
        add_text("H029716", 1'b0);
        add_text("H1", 1'b1);                  // cut inside length field
        add_frame(FK_GOOD, LPFC_MAX_PAYLOAD);
        while (stream_q.size() < STREAM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      add_frame(FK_GOOD, -1);
            else if (pick < 65) add_frame(FK_BAD_SUM, -1);
            else if (pick < 80) add_frame(FK_CUT, -1);
            else if (pick < 87) add_frame(FK_OVERSIZE, -1);
            else                add_noise();
        end
    endfunction

    task automatic send_stream();
        int idx;
        int burst_left;
        int gap_left;
        bit fire;
        idx        = 0;
        burst_left = $urandom_range(1, 12);
        gap_left   = 0;
        while (idx < stream_q.size()) begin
            if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left--;
            end else begin
                i_valid      <= 1'b1;
                i_data_byte  <= stream_q[idx].data;
                i_record_end <= stream_q[idx].rec_end;
            end
            @(negedge i_clk);
            fire = i_valid && !o_stall;
            @(posedge i_clk);
            if (fire) begin
                sb.note_word(stream_q[idx].data, stream_q[idx].rec_end);
                idx++;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        i_valid <= 1'b0;
    endtask

    // output side: random stall levels, plus one long hold-off
    initial begin
        int stall_pct;
        int mode_left;
        bit held;
        stall_pct = 0;
        mode_left = 0;
        held      = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sb.n_words >= 80) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 80;
                endcase
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_out_byte, o_frame_error, o_last);
    end

    initial begin
        sb = new();
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_data_byte  <= 8'h00;
        i_record_end <= 1'b0;
        build_stream();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_stream();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            $error("%0d results never arrived", sb.expected_q.size());
            sb.n_err++;
        end
        $display("Covered %0d input words: %0d frames passed, %0d frames dropped,",
                 sb.n_words, sb.n_good, sb.n_dropped);
        $display("%0d result words checked, %0d mismatches.", sb.n_results, sb.n_err);
        if (sb.n_err == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: length_prefixed_frame_checker_core.f
hw/rtl/lpfc_pkg.sv
hw/rtl/lpfc_ram.sv
hw/rtl/lpfc_datapath.sv
hw/rtl/lpfc_ctrl.sv
hw/rtl/length_prefixed_frame_checker_core.sv
verif/tb_top.sv
